>>> rtl/loop_current_sensor_scaler_unit_defines.svh
// assertion helpers used by lcss_datapath
`ifndef LOOP_CURRENT_SENSOR_SCALER_UNIT_DEFINES_SVH
`define LOOP_CURRENT_SENSOR_SCALER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LCSS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define LCSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lcss_pkg.sv
package lcss_pkg;

  // field widths
  localparam int ADC_W    = 23;
  localparam int STAT_W   = 2;
  localparam int SCALED_W = 32;

  // configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam int REG_IW = 3;

  // register indexes
  localparam logic [REG_IW-1:0] REG_INPUT_MODE  = 3'd0;
  localparam logic [REG_IW-1:0] REG_LOOP_GAIN   = 3'd1;
  localparam logic [REG_IW-1:0] REG_FIELD_GAIN  = 3'd2;
  localparam logic [REG_IW-1:0] REG_RANGE_LOW   = 3'd3;
  localparam logic [REG_IW-1:0] REG_RANGE_HIGH  = 3'd4;
  localparam logic [REG_IW-1:0] REG_TRIM_GAIN   = 3'd5;
  localparam logic [REG_IW-1:0] REG_TRIM_OFFSET = 3'd6;

  // register reset values
  localparam logic [15:0]        RST_LOOP_GAIN  = 16'd437;
  localparam logic [19:0]        RST_FIELD_GAIN = 20'd218453;
  localparam logic signed [31:0] RST_RANGE_LOW  = 32'sd0;
  localparam logic signed [31:0] RST_RANGE_HIGH = 32'sd10000;
  localparam logic [19:0]        RST_TRIM_GAIN  = 20'd65536;
  localparam logic signed [31:0] RST_TRIM_OFF   = 32'sd0;

  typedef logic [STAT_W-1:0] status_t;

  // status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_OPEN  = 2'd1;
  localparam status_t ST_UNDER = 2'd2;
  localparam status_t ST_OVER  = 2'd3;

  // configuration seen by the datapath
  typedef struct packed {
    logic               input_mode;
    logic [15:0]        loop_gain_q16;
    logic [19:0]        field_gain_q16;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic [19:0]        trim_gain_q16;
    logic signed [31:0] trim_offset;
  } cfg_t;

endpackage

>>> rtl/lcss_if.sv
// sample request channel
interface lcss_in_if import lcss_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ADC_W-1:0]  adc_uv;

  modport source (output valid, output adc_uv, input ready);
  modport sink (input valid, input adc_uv, output ready);
endinterface

// result request channel
interface lcss_out_if import lcss_pkg::*; ();
  logic                       valid;
  logic                       ready;
  status_t                    status;
  logic signed [SCALED_W-1:0] scaled_value;

  modport source (output valid, output status, output scaled_value, input ready);
  modport sink (input valid, input status, input scaled_value, output ready);
endinterface

>>> rtl/lcss_cfg_regs.sv
module lcss_cfg_regs import lcss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t              cfg_r;
  logic              wr_en;
  logic [REG_IW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg     = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.input_mode     <= 1'b0;
      cfg_r.loop_gain_q16  <= RST_LOOP_GAIN;
      cfg_r.field_gain_q16 <= RST_FIELD_GAIN;
      cfg_r.range_low      <= RST_RANGE_LOW;
      cfg_r.range_high     <= RST_RANGE_HIGH;
      cfg_r.trim_gain_q16  <= RST_TRIM_GAIN;
      cfg_r.trim_offset    <= RST_TRIM_OFF;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_INPUT_MODE:  cfg_r.input_mode     <= pwdata[0];
        REG_LOOP_GAIN:   cfg_r.loop_gain_q16  <= pwdata[15:0];
        REG_FIELD_GAIN:  cfg_r.field_gain_q16 <= pwdata[19:0];
        REG_RANGE_LOW:   cfg_r.range_low      <= $signed(pwdata);
        REG_RANGE_HIGH:  cfg_r.range_high     <= $signed(pwdata);
        REG_TRIM_GAIN:   cfg_r.trim_gain_q16  <= pwdata[19:0];
        REG_TRIM_OFFSET: cfg_r.trim_offset    <= $signed(pwdata);
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      REG_INPUT_MODE:  prdata = {31'd0, cfg_r.input_mode};
      REG_LOOP_GAIN:   prdata = {16'd0, cfg_r.loop_gain_q16};
      REG_FIELD_GAIN:  prdata = {12'd0, cfg_r.field_gain_q16};
      REG_RANGE_LOW:   prdata = cfg_r.range_low;
      REG_RANGE_HIGH:  prdata = cfg_r.range_high;
      REG_TRIM_GAIN:   prdata = {12'd0, cfg_r.trim_gain_q16};
      REG_TRIM_OFFSET: prdata = cfg_r.trim_offset;
      default:         prdata = '0;
    endcase
  end

endmodule

>>> rtl/lcss_datapath.sv
`include "loop_current_sensor_scaler_unit_defines.svh"

module lcss_datapath import lcss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  lcss_in_if.sink     in_chan,
  lcss_out_if.source  out_chan
);

  localparam int NSTG        = 9;
  localparam int PROD_W      = 44;
  localparam int N_W         = 40;
  localparam int A_W         = 23;
  localparam int M_W         = 27;
  localparam int Q_W         = 18;
  localparam int D_W         = 24;
  localparam int QD_W        = Q_W + D_W;
  localparam int FRAC_W      = 18;
  localparam int SPAN_W      = 33;
  localparam int FS_W        = FRAC_W + SPAN_W;
  localparam int VAL_W       = 35;
  localparam int TG_W        = 21;
  localparam int VT_W        = VAL_W + TG_W;
  localparam int RES_W       = 42;
  localparam int RECIP_SHIFT = 30;
  localparam int LOOP_ASHIFT = 10;
  localparam int VOLT_ASHIFT = 17;

  // status windows on the Q16 signal
  localparam logic signed [PROD_W-1:0] LOOP_OPEN  = PROD_W'(64'sd229376000);
  localparam logic signed [PROD_W-1:0] LOOP_OVER  = PROD_W'(64'sd1376256000);
  localparam logic signed [PROD_W-1:0] VOLT_UNDER = PROD_W'(-64'sd13107200000);
  localparam logic signed [PROD_W-1:0] VOLT_OVER  = PROD_W'(64'sd688128000000);

  // biases that make the dividend non-negative inside the window
  localparam logic signed [PROD_W-1:0] LOOP_BASE = PROD_W'(64'sd229376000);
  localparam logic signed [PROD_W-1:0] VOLT_BASE = PROD_W'(64'sd13110000000);
  localparam logic [Q_W-1:0] LOOP_QOFF = Q_W'(2048);
  localparam logic [Q_W-1:0] VOLT_QOFF = Q_W'(1311);

  // divisors and their scaled reciprocals
  localparam logic [D_W-1:0] LOOP_DIV   = D_W'(16000);
  localparam logic [D_W-1:0] VOLT_DIV   = D_W'(10000000);
  localparam logic [M_W-1:0] RECIP_LOOP = M_W'((64'd1 << 40) / 64'd16000);
  localparam logic [M_W-1:0] RECIP_VOLT = M_W'((64'd1 << 47) / 64'd10000000);

  // fraction clamp and output saturation
  localparam logic signed [FRAC_W:0] FRAC_MIN = -19'sd3277;
  localparam logic signed [FRAC_W:0] FRAC_MAX = 19'sd68813;
  localparam logic signed [RES_W-1:0] SAT_MAX = RES_W'(64'sd2147483647);
  localparam logic signed [RES_W-1:0] SAT_MIN = RES_W'(-64'sd2147483648);

  // per-stage valid bits and advance enables
  logic [NSTG:1] v_r;
  logic [NSTG:1] en;

  logic signed [PROD_W-1:0] prod1_r, prod1_nxt;
  status_t                  stat2_r, stat2_nxt;
  logic [N_W-1:0]           n2_r, n2_nxt;
  logic [A_W-1:0]           a2_r, a2_nxt;
  status_t                  stat3_r;
  logic [N_W-1:0]           n3_r;
  logic [Q_W-1:0]           qe3_r, qe3_nxt;
  status_t                  stat4_r;
  logic [N_W-1:0]           n4_r;
  logic [Q_W-1:0]           qe4_r;
  logic [QD_W-1:0]          qd4_r, qd4_nxt;
  status_t                  stat5_r;
  logic signed [FRAC_W-1:0] frac5_r, frac5_nxt;
  status_t                  stat6_r;
  logic signed [FS_W-1:0]   fs6_r, fs6_nxt;
  status_t                  stat7_r;
  logic signed [VAL_W-1:0]  val7_r, val7_nxt;
  status_t                  stat8_r;
  logic signed [VT_W-1:0]   vt8_r, vt8_nxt;
  status_t                  stat9_r;
  logic signed [SCALED_W-1:0] out9_r, out9_nxt;

  logic signed [SPAN_W-1:0] span_r;

  logic [19:0]               gain_sel;
  logic [M_W-1:0]            recip_sel;
  logic [D_W-1:0]            div_sel;
  logic [Q_W-1:0]            qoff_sel;
  logic signed [PROD_W-1:0]  nsum;
  logic [A_W+M_W-1:0]        qp;
  logic [QD_W-1:0]           rem;
  logic [QD_W-1:0]           rem_lim;
  logic [Q_W-1:0]            q_fix;
  logic signed [FRAC_W:0]    frac_w;
  logic signed [RES_W-1:0]   res;

  // mode selects
  always_comb begin
    if (cfg.input_mode) begin
      gain_sel  = cfg.field_gain_q16;
      recip_sel = RECIP_VOLT;
      div_sel   = VOLT_DIV;
      qoff_sel  = VOLT_QOFF;
    end else begin
      gain_sel  = {4'd0, cfg.loop_gain_q16};
      recip_sel = RECIP_LOOP;
      div_sel   = LOOP_DIV;
      qoff_sel  = LOOP_QOFF;
    end
  end

  // ready chain: a stage moves when empty or when the next one moves
  always_comb begin
    en[NSTG] = !v_r[NSTG] || out_chan.ready;
    for (int i = NSTG - 1; i >= 1; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_chan.ready         = en[1];
  assign out_chan.valid        = v_r[NSTG];
  assign out_chan.status       = stat9_r;
  assign out_chan.scaled_value = out9_r;

  // stage 1: signal = sample times gain
  always_comb begin
    prod1_nxt = $signed(in_chan.adc_uv) * $signed({1'b0, gain_sel});
  end

  // stage 2: status window, biased dividend and its top bits
  always_comb begin
    if (cfg.input_mode) begin
      if (prod1_r < VOLT_UNDER) begin
        stat2_nxt = ST_UNDER;
      end else if (prod1_r > VOLT_OVER) begin
        stat2_nxt = ST_OVER;
      end else begin
        stat2_nxt = ST_OK;
      end
      nsum   = prod1_r + VOLT_BASE;
      n2_nxt = nsum[N_W-1:0];
      a2_nxt = A_W'(n2_nxt >> VOLT_ASHIFT);
    end else begin
      if (prod1_r < LOOP_OPEN) begin
        stat2_nxt = ST_OPEN;
      end else if (prod1_r > LOOP_OVER) begin
        stat2_nxt = ST_OVER;
      end else begin
        stat2_nxt = ST_OK;
      end
      nsum   = prod1_r - LOOP_BASE;
      n2_nxt = nsum[N_W-1:0];
      a2_nxt = A_W'(n2_nxt >> LOOP_ASHIFT);
    end
  end

  // stage 3: quotient estimate by reciprocal, never above the true quotient
  always_comb begin
    qp      = {{M_W{1'b0}}, a2_r} * {{A_W{1'b0}}, recip_sel};
    qe3_nxt = qp[RECIP_SHIFT +: Q_W];
  end

  // stage 4: estimate times divisor
  always_comb begin
    qd4_nxt = {{D_W{1'b0}}, qe3_r} * {{Q_W{1'b0}}, div_sel};
  end

  // stage 5: one-step quotient correction, unbias and clamp the fraction
  always_comb begin
    rem     = {{(QD_W-N_W){1'b0}}, n4_r} - qd4_r;
    rem_lim = QD_W'({div_sel, 1'b0});
    q_fix   = qe4_r + Q_W'(rem >= QD_W'(div_sel));
    frac_w  = $signed({1'b0, q_fix}) - $signed({1'b0, qoff_sel});
    if (frac_w < FRAC_MIN) begin
      frac5_nxt = FRAC_W'(FRAC_MIN);
    end else if (frac_w > FRAC_MAX) begin
      frac5_nxt = FRAC_W'(FRAC_MAX);
    end else begin
      frac5_nxt = FRAC_W'(frac_w);
    end
  end

  // stage 6: fraction times span
  always_comb begin
    fs6_nxt = frac5_r * span_r;
  end

  // stage 7: value = low end plus scaled span
  always_comb begin
    val7_nxt = VAL_W'(fs6_r >>> 16) + VAL_W'($signed(cfg.range_low));
  end

  // stage 8: trim gain
  always_comb begin
    vt8_nxt = val7_r * $signed({1'b0, cfg.trim_gain_q16});
  end

  // stage 9: trim offset, saturate, zero on bad status
  always_comb begin
    res = RES_W'(vt8_r >>> 16) + RES_W'($signed(cfg.trim_offset));
    if (stat8_r != ST_OK) begin
      out9_nxt = '0;
    end else if (res > SAT_MAX) begin
      out9_nxt = SCALED_W'(SAT_MAX);
    end else if (res < SAT_MIN) begin
      out9_nxt = SCALED_W'(SAT_MIN);
    end else begin
      out9_nxt = SCALED_W'(res);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_chan.valid;
      end
      for (int i = 2; i <= NSTG; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // span follows the range registers
  always_ff @(posedge clk) begin
    span_r <= $signed(cfg.range_high) - $signed(cfg.range_low);
  end

  // stage payload registers
  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod1_r <= prod1_nxt;
    end
    if (en[2]) begin
      stat2_r <= stat2_nxt;
      n2_r    <= n2_nxt;
      a2_r    <= a2_nxt;
    end
    if (en[3]) begin
      stat3_r <= stat2_r;
      n3_r    <= n2_r;
      qe3_r   <= qe3_nxt;
    end
    if (en[4]) begin
      stat4_r <= stat3_r;
      n4_r    <= n3_r;
      qe4_r   <= qe3_r;
      qd4_r   <= qd4_nxt;
    end
    if (en[5]) begin
      stat5_r <= stat4_r;
      frac5_r <= frac5_nxt;
    end
    if (en[6]) begin
      stat6_r <= stat5_r;
      fs6_r   <= fs6_nxt;
    end
    if (en[7]) begin
      stat7_r <= stat6_r;
      val7_r  <= val7_nxt;
    end
    if (en[8]) begin
      stat8_r <= stat7_r;
      vt8_r   <= vt8_nxt;
    end
    if (en[9]) begin
      stat9_r <= stat8_r;
      out9_r  <= out9_nxt;
    end
  end

  // reciprocal estimate is off by at most one
  `LCSS_ASSERT_IMPLY(a_rem_window, v_r[4] && stat4_r == ST_OK, rem < rem_lim, "quotient estimate off by more than one")
  // clamped fraction stays in its window
  `LCSS_ASSERT_IMPLY(a_frac_window, v_r[5] && stat5_r == ST_OK, $signed({frac5_r[FRAC_W-1], frac5_r}) >= FRAC_MIN && $signed({frac5_r[FRAC_W-1], frac5_r}) <= FRAC_MAX, "fraction outside clamp")
  // a bad status carries a zero value
  `LCSS_ASSERT_IMPLY(a_zero_on_fault, v_r[NSTG] && stat9_r != ST_OK, out9_r == '0, "nonzero value with bad status")
  // each mode only raises its own low-side code
  `LCSS_ASSERT_IMPLY(a_mode_code, v_r[2], (cfg.input_mode && stat2_r != ST_OPEN) || (!cfg.input_mode && stat2_r != ST_UNDER), "status code does not fit mode")
  // a loop signal inside the window moves on as ok
  `LCSS_ASSERT_NEXT(a_loop_ok, v_r[1] && en[2] && !cfg.input_mode && prod1_r >= LOOP_OPEN && prod1_r <= LOOP_OVER, stat2_r == ST_OK, "in-window loop signal flagged")

endmodule

>>> rtl/loop_current_sensor_scaler_unit.sv
// Loop current / field voltage sensor scaler.
// in_chan carries one signed ADC sample in microvolts per request; out_chan
// returns one status code and one saturated engineering value per request, in
// order. Both channels use valid/ready; a request moves when both are high.
// The APB-style port (psel, penable, pwrite, paddr, pwdata, prdata, pready)
// holds the seven setup registers at byte addresses 0, 4, ... 24; pready is
// always high and a write lands on the access cycle. The user must make writes
// only while no request is in flight; the block does not enforce this.
// The datapath has nine register stages. Throughput is one request per cycle
// while the receiver keeps out_chan.ready high.
// The receiver may hold out_chan.ready low for any time: the output stage
// holds its result, each stage keeps its data until the next one is free,
// and empty stages keep filling, so in_chan.ready drops only once every
// stage is full.
// Reset (rst_n low at a clock edge) empties the pipeline and loads the
// register defaults: loop mode, 437 loop gain, unit trim, range 0..10000.
module loop_current_sensor_scaler_unit import lcss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  lcss_in_if.sink           in_chan,
  lcss_out_if.source        out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;

  // setup registers
  lcss_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // scaling pipeline
  lcss_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

endmodule
